// ===== design/pds_pkg.sv =====
// Package for the pump dispense sequencer: phase, motor and indicator codes,
// register map constants and shared types.
// No dependencies.
package pds_pkg;

  localparam int NumRegs  = 8;
  localparam int RegW     = 32;
  localparam int CfgAddrW = 5;

  typedef logic [RegW-1:0] reg_word_t;
  typedef reg_word_t [NumRegs-1:0] cfg_bank_t;

  // Register indexes in the configuration map.
  localparam logic [2:0] REG_PRE_ON_SHORT   = 3'd0;
  localparam logic [2:0] REG_PRE_OFF_SHORT  = 3'd1;
  localparam logic [2:0] REG_MAIN_ON_SHORT  = 3'd2;
  localparam logic [2:0] REG_MAIN_OFF_SHORT = 3'd3;
  localparam logic [2:0] REG_PRE_ON_LONG    = 3'd4;
  localparam logic [2:0] REG_PRE_OFF_LONG   = 3'd5;
  localparam logic [2:0] REG_MAIN_ON_LONG   = 3'd6;
  localparam logic [2:0] REG_MAIN_OFF_LONG  = 3'd7;

  localparam reg_word_t REG_RESET_VAL = 32'd1000;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PREON   = 3'd1;
  localparam logic [2:0] PH_PREOFF  = 3'd2;
  localparam logic [2:0] PH_WAIT    = 3'd3;
  localparam logic [2:0] PH_MAINON  = 3'd4;
  localparam logic [2:0] PH_MAINOFF = 3'd5;
  localparam logic [2:0] PH_REV     = 3'd6;

  // Motor commands.
  localparam logic [1:0] MOT_STOP = 2'd0;
  localparam logic [1:0] MOT_FWD  = 2'd1;
  localparam logic [1:0] MOT_REV  = 2'd2;

  // Indicator codes.
  localparam logic [1:0] IND_INSTALL = 2'd0;
  localparam logic [1:0] IND_READY   = 2'd1;
  localparam logic [1:0] IND_RUNNING = 2'd2;
  localparam logic [1:0] IND_EMPTY   = 2'd3;

endpackage

// ===== design/pds_in_if.sv =====
// Input channel of the pump dispense sequencer: one poll per transaction.
// Depends on nothing.
interface pds_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        short_mode;
  logic        start_pressed;
  logic        sensor1_level;
  logic        sensor2_level;
  logic        sensor3_level;

  modport source (
    output valid, now_ms, short_mode, start_pressed,
    output sensor1_level, sensor2_level, sensor3_level,
    input  ready
  );
  modport sink (
    input  valid, now_ms, short_mode, start_pressed,
    input  sensor1_level, sensor2_level, sensor3_level,
    output ready
  );
endinterface

// ===== design/pds_out_if.sv =====
// Result channel of the pump dispense sequencer: one status word per transaction.
// Depends on nothing.
interface pds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  motor_drive;
  logic [2:0]  phase;
  logic [1:0]  indicator;
  logic [15:0] pump_cycles;
  logic [3:0]  pre_cycles_done;

  modport source (
    output valid, motor_drive, phase, indicator, pump_cycles, pre_cycles_done,
    input  ready
  );
  modport sink (
    input  valid, motor_drive, phase, indicator, pump_cycles, pre_cycles_done,
    output ready
  );
endinterface

// ===== design/pump_dispense_sequencer.sv =====
// Pump dispense sequencer top level: poll input register, phase state machine
// and result register. Depends on pds_pkg, pds_in_if, pds_out_if and pds_cfg.
//
// Usage: every transaction on in_ch is one poll (timestamp, mode switch, start
// button, three raw sensor levels). For each poll exactly one transaction comes
// out on out_ch with the motor command, phase, indicator, main pump cycle count
// and pre-pump cycle count as they stand after that poll.
// The poll is captured in an input register, and the next state is computed
// from it in one pass (one 32-bit subtract and compare against the selected
// period) and written into the result register together with the state once
// the result register is free.
// Throughput is one poll per cycle while out_ch does not stall; the state
// update, registered with the result, is the loop that sets it. A result waiting
// on a stalled out_ch does not block the poll behind it: that poll is held in
// the input register, and in_ch.ready drops only when both registers are full.
// Timing registers are to be written over the cfg_ APB port (register i at byte
// address 4*i) only while no poll is in flight; the block itself does not enforce it.
// Synchronous reset puts the block in idle with the motor stopped, counts
// cleared and all timings at 1000 ms.
module pump_dispense_sequencer import pds_pkg::*; #(
  parameter int          PRE_REPEATS = 3,
  parameter int unsigned WAIT_MS     = 900000
) (
  input  logic                clk,
  input  logic                rst_n,
  pds_in_if.sink              in_ch,
  pds_out_if.source           out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [RegW-1:0]     cfg_pwdata,
  output logic [RegW-1:0]     cfg_prdata,
  output logic                cfg_pready
);

  localparam logic [3:0]  PreRepeats = 4'(PRE_REPEATS);
  localparam logic [31:0] WaitMs     = 32'(WAIT_MS);

  cfg_bank_t regs;

  pds_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  // Input register.
  logic        in_v_r;
  logic [31:0] now_r;
  logic        short_r, start_r, lvl1_r, lvl2_r, lvl3_r;

  // Sequencer state.
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] start_ms_r, start_ms_nxt;
  logic [3:0]  pre_cnt_r, pre_cnt_nxt;
  logic [15:0] main_cnt_r, main_cnt_nxt;
  logic [1:0]  motor_r, motor_nxt;
  logic [1:0]  ind_r, ind_nxt;

  // Result register.
  logic        out_v_r;
  logic [1:0]  o_motor_r, o_ind_r;
  logic [2:0]  o_phase_r;
  logic [15:0] o_main_r;
  logic [3:0]  o_pre_r;

  logic        out_free, advance, in_fire;
  logic        s1, s2, s3;
  logic [31:0] p_on, p_off, m_on, m_off, period, elapsed;
  logic        expired;
  logic [3:0]  pre_inc;

  assign out_free    = !out_v_r || out_ch.ready;
  assign advance     = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r   <= in_ch.now_ms;
      short_r <= in_ch.short_mode;
      start_r <= in_ch.start_pressed;
      lvl1_r  <= in_ch.sensor1_level;
      lvl2_r  <= in_ch.sensor2_level;
      lvl3_r  <= in_ch.sensor3_level;
    end
  end

  assign s1 = !lvl1_r;
  assign s2 = lvl2_r;
  assign s3 = !lvl3_r;

  assign p_on  = short_r ? regs[REG_PRE_ON_SHORT]   : regs[REG_PRE_ON_LONG];
  assign p_off = short_r ? regs[REG_PRE_OFF_SHORT]  : regs[REG_PRE_OFF_LONG];
  assign m_on  = short_r ? regs[REG_MAIN_ON_SHORT]  : regs[REG_MAIN_ON_LONG];
  assign m_off = short_r ? regs[REG_MAIN_OFF_SHORT] : regs[REG_MAIN_OFF_LONG];

  always_comb begin
    case (phase_r)
      PH_PREON:   period = p_on;
      PH_PREOFF:  period = p_off;
      PH_WAIT:    period = WaitMs;
      PH_MAINON:  period = m_on;
      PH_MAINOFF: period = m_off;
      default:    period = WaitMs;
    endcase
  end

  // Elapsed time wraps with the timestamp.
  assign elapsed = now_r - start_ms_r;
  assign expired = elapsed >= period;
  assign pre_inc = pre_cnt_r + 4'd1;

  always_comb begin
    // A sensor pattern outside the four known ones keeps the last indicator.
    ind_nxt = ind_r;
    if (!s1 && !s2 && !s3) begin
      ind_nxt = IND_INSTALL;
    end else if (!s1 && !s2 && s3) begin
      ind_nxt = IND_READY;
    end else if (s1 && !s2 && s3) begin
      ind_nxt = IND_RUNNING;
    end else if (!s1 && s2 && s3) begin
      ind_nxt = IND_EMPTY;
    end

    phase_nxt    = phase_r;
    start_ms_nxt = start_ms_r;
    pre_cnt_nxt  = pre_cnt_r;
    main_cnt_nxt = main_cnt_r;
    motor_nxt    = motor_r;

    case (phase_r)
      PH_PREON: begin
        if (expired) begin
          motor_nxt    = MOT_STOP;
          start_ms_nxt = now_r;
          phase_nxt    = PH_PREOFF;
        end
      end
      PH_PREOFF: begin
        if (expired) begin
          pre_cnt_nxt  = pre_inc;
          start_ms_nxt = now_r;
          if (pre_inc < PreRepeats) begin
            motor_nxt = MOT_FWD;
            phase_nxt = PH_PREON;
          end else begin
            phase_nxt = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (expired) begin
          motor_nxt    = MOT_FWD;
          start_ms_nxt = now_r;
          phase_nxt    = PH_MAINON;
        end
      end
      PH_MAINON, PH_MAINOFF: begin
        // A timer expiry on the same poll as sensor two is still counted.
        if (expired) begin
          start_ms_nxt = now_r;
          if (phase_r == PH_MAINON) begin
            motor_nxt    = MOT_STOP;
            phase_nxt    = PH_MAINOFF;
            main_cnt_nxt = main_cnt_r + 16'd1;
          end else begin
            motor_nxt = MOT_FWD;
            phase_nxt = PH_MAINON;
          end
        end
        if (s2) begin
          motor_nxt    = MOT_REV;
          start_ms_nxt = now_r;
          phase_nxt    = PH_REV;
        end
      end
      PH_REV: begin
        if (s1) begin
          motor_nxt = MOT_STOP;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        // Idle, and the unused phase code which falls back to idle.
        phase_nxt = PH_IDLE;
        if (start_r) begin
          pre_cnt_nxt  = 4'd0;
          start_ms_nxt = now_r;
          phase_nxt    = PH_PREON;
          motor_nxt    = MOT_FWD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      start_ms_r <= 32'd0;
      pre_cnt_r  <= 4'd0;
      main_cnt_r <= 16'd0;
      motor_r    <= MOT_STOP;
      ind_r      <= IND_INSTALL;
      out_v_r    <= 1'b0;
    end else begin
      if (advance) begin
        phase_r    <= phase_nxt;
        start_ms_r <= start_ms_nxt;
        pre_cnt_r  <= pre_cnt_nxt;
        main_cnt_r <= main_cnt_nxt;
        motor_r    <= motor_nxt;
        ind_r      <= ind_nxt;
      end
      if (out_free) begin
        out_v_r <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_motor_r <= motor_nxt;
      o_phase_r <= phase_nxt;
      o_ind_r   <= ind_nxt;
      o_main_r  <= main_cnt_nxt;
      o_pre_r   <= pre_cnt_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.motor_drive     = o_motor_r;
  assign out_ch.phase           = o_phase_r;
  assign out_ch.indicator       = o_ind_r;
  assign out_ch.pump_cycles     = o_main_r;
  assign out_ch.pre_cycles_done = o_pre_r;

  // The motor runs in reverse exactly while the sequencer is reversing.
  a_rev_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (motor_r == MOT_REV) == (phase_r == PH_REV))
    else $error("motor reverse and reversing phase disagree");

  // The pre-pump count never passes the repeat target.
  a_pre_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pre_cnt_r <= PreRepeats)
    else $error("pre-pump count beyond repeat target");

  // The main cycle count only moves when a main-on period ends.
  a_main_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (main_cnt_r != $past(main_cnt_r)) |->
      ($past(phase_r) == PH_MAINON && $past(advance)))
    else $error("main cycle count changed outside main-on");

endmodule

// ===== design/pds_cfg.sv =====
// APB-style register bank holding the eight timing registers.
// Depends on pds_pkg.
module pds_cfg import pds_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [RegW-1:0]     pwdata,
  output logic [RegW-1:0]     prdata,
  output logic                pready,
  output cfg_bank_t           regs
);

  cfg_bank_t   regs_r;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[CfgAddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = regs_r[idx];
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_r[i] <= REG_RESET_VAL;
      end
    end else if (wr_en) begin
      regs_r[idx] <= pwdata;
    end
  end

endmodule

// ===== verif/tb_pump_dispense_sequencer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pump_dispense_sequencer: drives polls and timing registers
// and checks every status transaction against an in-bench sequencer model.
// Depends on pds_pkg, pds_in_if, pds_out_if and the pump_dispense_sequencer RTL.
module tb_pump_dispense_sequencer;
  import pds_pkg::*;

  localparam int          PRE_REPEATS = 3;
  localparam int unsigned WAIT_MS     = 900000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        short_mode;
    logic        start_pressed;
    logic        sensor1_level;
    logic        sensor2_level;
    logic        sensor3_level;
  } poll_t;

  typedef struct packed {
    logic [1:0]  motor_drive;
    logic [2:0]  phase;
    logic [1:0]  indicator;
    logic [15:0] pump_cycles;
    logic [3:0]  pre_cycles_done;
  } status_t;

  logic clk;
  logic rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [RegW-1:0]     cfg_pwdata;
  logic [RegW-1:0]     cfg_prdata;
  logic                cfg_pready;

  pds_in_if  in_ch ();
  pds_out_if out_ch ();

  pump_dispense_sequencer #(
    .PRE_REPEATS(PRE_REPEATS),
    .WAIT_MS    (WAIT_MS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Sequencer model state and its copy of the timing registers.
  cfg_bank_t   timing_cfg;
  logic [2:0]  seq_phase      = PH_IDLE;
  reg_word_t   seq_start_ms   = '0;
  logic [3:0]  seq_pre_count  = '0;
  logic [15:0] seq_main_count = '0;
  logic [1:0]  seq_motor      = MOT_STOP;
  logic [1:0]  seq_indicator  = IND_INSTALL;

  poll_t     pending_polls[$];
  status_t   expected_status[$];
  poll_t     poll_on_bus;
  reg_word_t poll_clock;
  int        send_gap;
  int        stall_left;
  logic      idling_enabled;
  int        polls_accepted;
  int        results_checked;
  int        fail_count;
  int        settings_run;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (!idling_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic timer_done(reg_word_t now, reg_word_t period);
    reg_word_t elapsed;
    elapsed = now - seq_start_ms;
    return elapsed >= period;
  endfunction

  // Advances the sequencer model by one poll and queues the status it produces.
  function automatic void step_sequencer(poll_t p);
    logic      s1, s2, s3;
    reg_word_t on_ms, off_ms, main_on_ms, main_off_ms;
    status_t   st;
    s1 = !p.sensor1_level;
    s2 = p.sensor2_level;
    s3 = !p.sensor3_level;
    if (p.short_mode) begin
      on_ms       = timing_cfg[REG_PRE_ON_SHORT];
      off_ms      = timing_cfg[REG_PRE_OFF_SHORT];
      main_on_ms  = timing_cfg[REG_MAIN_ON_SHORT];
      main_off_ms = timing_cfg[REG_MAIN_OFF_SHORT];
    end else begin
      on_ms       = timing_cfg[REG_PRE_ON_LONG];
      off_ms      = timing_cfg[REG_PRE_OFF_LONG];
      main_on_ms  = timing_cfg[REG_MAIN_ON_LONG];
      main_off_ms = timing_cfg[REG_MAIN_OFF_LONG];
    end

    // Sensor patterns that match none of these leave the indicator alone.
    case ({s1, s2, s3})
      3'b000:  seq_indicator = IND_INSTALL;
      3'b001:  seq_indicator = IND_READY;
      3'b101:  seq_indicator = IND_RUNNING;
      3'b011:  seq_indicator = IND_EMPTY;
      default: ;
    endcase

    case (seq_phase)
      PH_PREON: begin
        if (timer_done(p.now_ms, on_ms)) begin
          seq_motor    = MOT_STOP;
          seq_start_ms = p.now_ms;
          seq_phase    = PH_PREOFF;
        end
      end
      PH_PREOFF: begin
        if (timer_done(p.now_ms, off_ms)) begin
          seq_pre_count = seq_pre_count + 4'd1;
          seq_start_ms  = p.now_ms;
          if (seq_pre_count < 4'(PRE_REPEATS)) begin
            seq_motor = MOT_FWD;
            seq_phase = PH_PREON;
          end else begin
            seq_phase = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (timer_done(p.now_ms, WAIT_MS)) begin
          seq_motor    = MOT_FWD;
          seq_start_ms = p.now_ms;
          seq_phase    = PH_MAINON;
        end
      end
      PH_MAINON, PH_MAINOFF: begin
        // The timer is handled first, so an expiry on the same poll as sensor two
        // still counts a main pump cycle.
        if (seq_phase == PH_MAINON) begin
          if (timer_done(p.now_ms, main_on_ms)) begin
            seq_motor      = MOT_STOP;
            seq_start_ms   = p.now_ms;
            seq_phase      = PH_MAINOFF;
            seq_main_count = seq_main_count + 16'd1;
          end
        end else if (timer_done(p.now_ms, main_off_ms)) begin
          seq_motor    = MOT_FWD;
          seq_start_ms = p.now_ms;
          seq_phase    = PH_MAINON;
        end
        if (s2) begin
          seq_motor    = MOT_REV;
          seq_start_ms = p.now_ms;
          seq_phase    = PH_REV;
        end
      end
      PH_REV: begin
        if (s1) begin
          seq_motor = MOT_STOP;
          seq_phase = PH_IDLE;
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        if (p.start_pressed) begin
          seq_pre_count = '0;
          seq_start_ms  = p.now_ms;
          seq_phase     = PH_PREON;
          seq_motor     = MOT_FWD;
        end
      end
    endcase

    st.motor_drive     = seq_motor;
    st.phase           = seq_phase;
    st.indicator       = seq_indicator;
    st.pump_cycles     = seq_main_count;
    st.pre_cycles_done = seq_pre_count;
    expected_status.push_back(st);
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Poll driver: one transaction per queued poll, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        step_sequencer(poll_on_bus);
        polls_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_polls.size() != 0) begin
          poll_on_bus = pending_polls.pop_front();
          in_ch.now_ms        <= poll_on_bus.now_ms;
          in_ch.short_mode    <= poll_on_bus.short_mode;
          in_ch.start_pressed <= poll_on_bus.start_pressed;
          in_ch.sensor1_level <= poll_on_bus.sensor1_level;
          in_ch.sensor2_level <= poll_on_bus.sensor2_level;
          in_ch.sensor3_level <= poll_on_bus.sensor3_level;
          in_ch.valid         <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor: checks each transaction and stalls ready at random.
  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_status.size() == 0) begin
          $error("status transaction with no poll waiting for it");
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("motor_drive", 32'(want.motor_drive), 32'(out_ch.motor_drive));
          check_field("phase", 32'(want.phase), 32'(out_ch.phase));
          check_field("indicator", 32'(want.indicator), 32'(out_ch.indicator));
          check_field("pump_cycles", 32'(want.pump_cycles), 32'(out_ch.pump_cycles));
          check_field("pre_cycles_done", 32'(want.pre_cycles_done),
                      32'(out_ch.pre_cycles_done));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready) stall_left = pick_gap();
      end
    end
  end

  task automatic add_poll(reg_word_t dt, logic mode, logic start, logic l1, logic l2, logic l3);
    poll_t p;
    poll_clock = poll_clock + dt;
    p.now_ms        = poll_clock;
    p.short_mode    = mode;
    p.start_pressed = start;
    p.sensor1_level = l1;
    p.sensor2_level = l2;
    p.sensor3_level = l3;
    pending_polls.push_back(p);
  endtask

  // Returns once every poll has gone out and every status has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_polls.size() != 0 || in_ch.valid || expected_status.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, reg_word_t value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    timing_cfg[idx] = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // One dispense attempt: a start press followed by polls whose time steps aim at
  // the configured periods and the fixed wait. Sensor two and sensor one show up
  // mostly late in the run, so that it tends to end in reversing and back to idle.
  task automatic gen_run(int len);
    logic      mode, late, l1, l2, l3;
    int        r;
    reg_word_t dt;
    mode = 1'($urandom_range(0, 1));
    add_poll($urandom_range(0, 50), mode, 1'b1, 1'b1, 1'b0, 1'b0);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) mode = ~mode;
      r = $urandom_range(0, 99);
      if (r < 20)      dt = $urandom_range(0, 2);
      else if (r < 50) dt = $urandom_range(0, 70);
      else if (r < 70) dt = timing_cfg[(mode ? REG_PRE_ON_SHORT : REG_PRE_ON_LONG)
                                       + 3'($urandom_range(0, 3))]
                            - $urandom_range(0, 1);
      else if (r < 85) dt = $urandom_range(300000, 950000);
      else if (r < 90) dt = WAIT_MS - $urandom_range(0, 1);
      else if (r < 95) dt = $urandom();
      else             dt = 32'hFFFF_FFFF - $urandom_range(0, 2);
      late = (i * 4 > len * 3);
      l2 = ($urandom_range(0, 99) < (late ? 25 : 2));
      l1 = !($urandom_range(0, 99) < (late ? 30 : 8));
      l3 = ($urandom_range(0, 99) < 30);
      add_poll(dt, mode, ($urandom_range(0, 19) == 0), l1, l2, l3);
    end
  endtask

  initial begin
    int        pushed;
    logic      paused;
    reg_word_t value;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.now_ms        = '0;
    in_ch.short_mode    = 1'b0;
    in_ch.start_pressed = 1'b0;
    in_ch.sensor1_level = 1'b0;
    in_ch.sensor2_level = 1'b0;
    in_ch.sensor3_level = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    for (int i = 0; i < NumRegs; i++) timing_cfg[i] = REG_RESET_VAL;
    send_gap        = 0;
    stall_left      = 0;
    idling_enabled  = 1'b1;
    polls_accepted  = 0;
    results_checked = 0;
    fail_count      = 0;
    settings_run    = 1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk through the whole sequence with the reset timings. The
    // timestamp starts just below the 32-bit wrap so that the early periods
    // straddle it. Levels are (sensor1, sensor2, sensor3) raw.
    poll_clock = 32'hFFFF_FC00;
    add_poll(0,      1, 0, 1, 0, 1);   // idle, install refill pattern
    add_poll(0,      1, 1, 1, 0, 0);   // start, ready pattern
    add_poll(999,    1, 0, 0, 1, 1);   // one short of the period, unmatched pattern
    add_poll(1,      0, 0, 0, 0, 0);   // expires just below the wrap, running pattern
    add_poll(1000,   0, 1, 0, 0, 0);   // start outside idle is ignored, across the wrap
    add_poll(1000,   1, 0, 1, 0, 0);
    add_poll(1000,   1, 0, 1, 0, 0);
    add_poll(1000,   1, 0, 1, 0, 0);
    add_poll(999,    1, 0, 1, 0, 0);
    add_poll(1,      1, 0, 1, 0, 0);   // third pre-pump cycle, into the wait
    add_poll(899999, 1, 0, 1, 0, 0);
    add_poll(1,      1, 0, 1, 0, 0);   // wait ends exactly on the boundary
    add_poll(1000,   1, 0, 1, 0, 0);   // first main pump cycle counted
    add_poll(500,    1, 0, 1, 1, 0);   // sensor two without expiry, empty pattern
    add_poll(10,     1, 0, 1, 0, 0);   // reversing holds while sensor one is quiet
    add_poll(10,     1, 0, 0, 0, 0);   // sensor one ends the reversing
    add_poll(5,      0, 1, 1, 0, 0);   // restart keeps the main count
    for (int i = 0; i < 6; i++) add_poll(1000, 0, 0, 1, 0, 0);
    add_poll(WAIT_MS, 0, 0, 1, 0, 0);
    add_poll(1000,   0, 0, 1, 1, 0);   // expiry and sensor two on the same poll
    add_poll(3,      0, 0, 0, 1, 1);   // back to idle, unmatched pattern
    wait_drained();

    // Random dispense runs under several timing settings, the extremes first.
    for (int ph = 0; ph < 7; ph++) begin
      for (int r = 0; r < NumRegs; r++) begin
        case (ph)
          0: value = '0;
          1: value = 32'hFFFF_FFFF;
          default: begin
            case ($urandom_range(0, 9))
              0:       value = '0;
              1:       value = 32'd1;
              6:       value = REG_RESET_VAL;
              7:       value = $urandom();
              8:       value = 32'hFFFF_FFFF;
              default: value = $urandom_range(1, 40);
            endcase
          end
        endcase
        write_reg(r[2:0], value);
      end
      settings_run++;
      pushed = 0;
      paused = 1'b0;
      poll_clock = $urandom();
      while (pushed < 175) begin
        // Hold the poll stream once until the block has emptied completely.
        if (ph == 3 && !paused && pushed >= 90) begin
          wait_drained();
          paused = 1'b1;
        end
        idling_enabled = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) == 0) begin
          for (int k = $urandom_range(1, 5); k > 0; k--) begin
            add_poll($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            pushed++;
          end
        end else begin
          value = $urandom_range(10, 60);
          gen_run(value);
          pushed += value;
        end
      end
      wait_drained();
    end

    // Zero periods: every main poll flips between on and off, so the pump
    // cycle count moves on every other poll.
    idling_enabled = 1'b1;
    for (int r = 0; r < NumRegs; r++) write_reg(r[2:0], '0);
    settings_run++;
    idling_enabled = 1'b0;
    for (int i = 0; i < 8; i++) add_poll(WAIT_MS, 1, 0, 1, 0, 0);
    add_poll(1, 1, 0, 1, 1, 0);
    add_poll(1, 1, 0, 0, 0, 0);
    add_poll(1, 1, 1, 1, 0, 0);
    for (int i = 0; i < 7; i++) add_poll(WAIT_MS, 1, 0, 1, 0, 0);
    for (int i = 0; i < 40; i++) add_poll($urandom_range(0, 3), 1, 0, 1, 0, 0);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("Ran %0d polls through %0d timing settings; %0d status results compared.",
             polls_accepted, settings_run, results_checked);
    $display("Covered all seven phases, wrapping timestamps and zero and maximum periods.");
    if (fail_count == 0) begin
      $display("pump_dispense_sequencer verification clean");
    end else begin
      $display("pump_dispense_sequencer verification failed");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Timed out with %0d polls queued and %0d results outstanding.",
             pending_polls.size(), expected_status.size());
    $display("pump_dispense_sequencer verification failed");
    $finish;
  end

endmodule
